### rtl/s2i_pkg.sv
// Shared types, constants and character decoding for the string-to-integer parser.
`default_nettype none

package s2i_pkg;

    localparam int MAX_LEN        = 256;
    localparam int POS_W          = $clog2(MAX_LEN + 1);
    localparam int VALUE_BITS_DEF = 64;
    localparam int OUT_BITS       = 64;
    localparam int RADIX_W        = 6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;

    typedef enum logic [2:0] {
        PH_WS     = 3'd0,
        PH_START  = 3'd1,
        PH_ZERO   = 3'd2,
        PH_XSEEN  = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0]         char_code;
        logic               is_first;
        logic [RADIX_W-1:0] base_in;
        logic               is_last;
    } req_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] value;
        logic [POS_W-1:0]           end_offset;
        logic                       any_digits;
    } rsp_t;

    typedef struct packed {
        phase_t             phase;
        logic               negative;
        logic [RADIX_W-1:0] radix;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   stop_offset;
        logic               seen_digit;
    } ctl_t;

    localparam ctl_t CTL_RESET = '{
        phase:       PH_WS,
        negative:    1'b0,
        radix:       RADIX_DEC,
        position:    '0,
        stop_offset: '0,
        seen_digit:  1'b0
    };

    typedef struct packed {
        logic               ok;
        logic [RADIX_W-1:0] val;
    } digit_t;

    function automatic digit_t char_digit(input logic [7:0] c);
        digit_t d;
        d.ok  = 1'b1;
        d.val = '0;
        if (c >= CH_0 && c <= CH_9)
        begin
            d.val = RADIX_W'(c - CH_0);
        end
        else if (c >= CH_LA && c <= CH_LZ)
        begin
            d.val = RADIX_W'(c - CH_LA) + RADIX_DEC;
        end
        else if (c >= CH_UA && c <= CH_UZ)
        begin
            d.val = RADIX_W'(c - CH_UA) + RADIX_DEC;
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    endfunction

endpackage

`default_nettype wire

### rtl/s2i_step.sv
// Per-character parse step: next parse state, multiply-add and the result item.
`default_nettype none

module s2i_step #(
    parameter int VALUE_BITS = s2i_pkg::VALUE_BITS_DEF
) (
    input  s2i_pkg::req_t          item,
    input  s2i_pkg::ctl_t          ctl,
    input  logic [VALUE_BITS-1:0]  acc,
    output s2i_pkg::ctl_t          ctl_next,
    output logic [VALUE_BITS-1:0]  acc_next,
    output s2i_pkg::rsp_t          result
);

    s2i_pkg::ctl_t                       cur;
    logic [VALUE_BITS-1:0]               cur_acc;
    s2i_pkg::digit_t                     dig;
    logic                                start;
    logic                                take;
    logic [s2i_pkg::RADIX_W-1:0]         rad;
    logic [s2i_pkg::POS_W-1:0]           pos_inc;
    logic [VALUE_BITS+s2i_pkg::RADIX_W-1:0] prod;
    logic [VALUE_BITS-1:0]               mag;

    always_comb
    begin
        cur     = ctl;
        cur_acc = acc;
        if (item.is_first)
        begin
            cur       = s2i_pkg::CTL_RESET;
            cur.radix = item.base_in;
            cur_acc   = '0;
        end

        ctl_next = cur;
        acc_next = cur_acc;
        dig      = s2i_pkg::char_digit(item.char_code);
        start    = 1'b0;
        take     = 1'b0;
        rad      = cur.radix;
        pos_inc  = (cur.position == s2i_pkg::POS_W'(s2i_pkg::MAX_LEN)) ?
                   cur.position : cur.position + 1'b1;

        unique case (cur.phase)
            s2i_pkg::PH_WS:
            begin
                if (s2i_pkg::is_space(item.char_code))
                begin
                    ctl_next.phase = s2i_pkg::PH_WS;
                end
                else if (item.char_code == s2i_pkg::CH_MINUS)
                begin
                    ctl_next.negative = 1'b1;
                    ctl_next.phase    = s2i_pkg::PH_START;
                end
                else if (item.char_code == s2i_pkg::CH_PLUS)
                begin
                    ctl_next.phase = s2i_pkg::PH_START;
                end
                else
                begin
                    start = 1'b1;
                end
            end
            s2i_pkg::PH_START:
            begin
                start = 1'b1;
            end
            s2i_pkg::PH_ZERO:
            begin
                if (item.char_code == s2i_pkg::CH_LX || item.char_code == s2i_pkg::CH_UX)
                begin
                    ctl_next.phase = s2i_pkg::PH_XSEEN;
                end
                else
                begin
                    rad  = (cur.radix == s2i_pkg::RADIX_AUTO) ? s2i_pkg::RADIX_OCT : cur.radix;
                    take = 1'b1;
                end
            end
            s2i_pkg::PH_XSEEN:
            begin
                // Prefix counts only if a hex digit follows it
                if (dig.ok && dig.val < s2i_pkg::RADIX_HEX)
                begin
                    ctl_next.radix       = s2i_pkg::RADIX_HEX;
                    acc_next             = VALUE_BITS'(dig.val);
                    ctl_next.stop_offset = pos_inc;
                    ctl_next.phase       = s2i_pkg::PH_DIGITS;
                end
                else
                begin
                    ctl_next.phase = s2i_pkg::PH_DONE;
                end
            end
            s2i_pkg::PH_DIGITS:
            begin
                take = 1'b1;
            end
            s2i_pkg::PH_DONE:
            begin
                ctl_next.phase = s2i_pkg::PH_DONE;
            end
            default:
            begin
                ctl_next.phase = cur.phase;
            end
        endcase

        if (start)
        begin
            if ((cur.radix == s2i_pkg::RADIX_AUTO || cur.radix == s2i_pkg::RADIX_HEX) &&
                item.char_code == s2i_pkg::CH_0)
            begin
                acc_next             = '0;
                ctl_next.seen_digit  = 1'b1;
                ctl_next.stop_offset = pos_inc;
                ctl_next.phase       = s2i_pkg::PH_ZERO;
            end
            else
            begin
                rad  = (cur.radix == s2i_pkg::RADIX_AUTO) ? s2i_pkg::RADIX_DEC : cur.radix;
                take = 1'b1;
            end
        end

        prod = cur_acc * rad;

        if (take)
        begin
            ctl_next.radix = rad;
            ctl_next.phase = s2i_pkg::PH_DIGITS;
            if (dig.ok && dig.val < rad)
            begin
                acc_next             = prod[VALUE_BITS-1:0] + VALUE_BITS'(dig.val);
                ctl_next.seen_digit  = 1'b1;
                ctl_next.stop_offset = pos_inc;
            end
            else
            begin
                ctl_next.phase = s2i_pkg::PH_DONE;
            end
        end

        ctl_next.position = pos_inc;

        mag                = ctl_next.negative ? (~acc_next + 1'b1) : acc_next;
        result.value       = s2i_pkg::OUT_BITS'($signed(mag));
        result.end_offset  = ctl_next.seen_digit ? ctl_next.stop_offset : '0;
        result.any_digits  = ctl_next.seen_digit;

        // End of string: drop all parse state
        if (item.is_last)
        begin
            ctl_next = s2i_pkg::CTL_RESET;
            acc_next = '0;
        end
    end

endmodule

`default_nettype wire

### rtl/string_to_integer_parser_core.sv
// Top level of the string-to-integer parser: request register, parse state, result register.
`default_nettype none

// Parses a character stream into a signed integer the way strtol does: one
// character per request, the first flagged by is_first (which also samples
// base_in, 0 for auto-detect) and the last by is_last, after which one result
// carries the value (wrapping at VALUE_BITS, sign-extended to 64 bits), the
// consumed length and a digit flag. The block takes one request every cycle
// while req_stall is low; a request lands in an input register and, once the
// result register is free, a single multiply-add by the radix updates the
// parse state and, on the last character, loads the result register and
// raises rsp_valid. req_stall rises while a finished result is held by
// rsp_stall and a request is waiting in the input register.
module string_to_integer_parser_core #(
    parameter int VALUE_BITS = s2i_pkg::VALUE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  s2i_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output s2i_pkg::rsp_t  rsp
);

    logic                  req_vld_reg;
    s2i_pkg::req_t         req_data_reg;
    s2i_pkg::ctl_t         ctl_reg;
    s2i_pkg::ctl_t         ctl_next;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] acc_next;
    logic                  rsp_vld_reg;
    s2i_pkg::rsp_t         rsp_data_reg;
    s2i_pkg::rsp_t         step_result;
    logic                  rsp_free;
    logic                  advance;

    assign rsp_free  = !rsp_vld_reg || !rsp_stall;
    assign advance   = req_vld_reg && rsp_free;
    assign req_stall = req_vld_reg && !rsp_free;

    s2i_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .item     (req_data_reg),
        .ctl      (ctl_reg),
        .acc      (acc_reg),
        .ctl_next (ctl_next),
        .acc_next (acc_next),
        .result   (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            req_vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_data_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= s2i_pkg::CTL_RESET;
            acc_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (rsp_free)
        begin
            rsp_vld_reg <= advance && req_data_reg.is_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && req_data_reg.is_last)
        begin
            rsp_data_reg <= step_result;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_data_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("request stalled while result register was free");

    a_position_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.position <= s2i_pkg::POS_W'(s2i_pkg::MAX_LEN))
        else $error("position ran past its saturation limit");

    a_stop_needs_digit: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl_reg.seen_digit |-> (ctl_reg.stop_offset == '0))
        else $error("stop offset moved without a digit");

    a_offset_zero_no_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.any_digits) |-> (rsp.end_offset == '0))
        else $error("nonzero offset reported without digits");
`endif

endmodule

`default_nettype wire

### tb/tb_string_to_integer_parser_core.sv
// Self-checking testbench for the string-to-integer parser core.
`timescale 1ns / 100ps

module tb_string_to_integer_parser_core;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1250;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    s2i_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    s2i_pkg::rsp_t rsp;

    string_to_integer_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // A typed-in result replaces the computed one for the string it belongs to.
    typedef struct {
        bit            pinned;
        s2i_pkg::rsp_t want;
    } pin_t;

    typedef struct {
        string                       text;
        logic [s2i_pkg::RADIX_W-1:0] base;
        bit                          no_first;
        bit                          nul_end;
        bit                          pinned;
        logic signed [63:0]          value;
        int                          offset;
        bit                          any;
    } case_row_t;

    case_row_t dir_tab [25] = '{
        '{"  \t\n\015\013\014-123", 10, 0, 0, 1, -123, 11, 1},
        '{"+0x1F", 0, 0, 0, 1, 31, 5, 1},
        '{"0x", 16, 0, 0, 1, 0, 1, 1},
        '{"0xg", 0, 0, 0, 1, 0, 1, 1},
        '{"0X7fFf", 16, 0, 0, 1, 32767, 6, 1},
        '{"0755", 0, 0, 0, 1, 493, 4, 1},
        '{"0789", 0, 0, 0, 1, 7, 2, 1},
        '{"00x5", 0, 0, 0, 1, 0, 2, 1},
        '{"18446744073709551615", 10, 0, 0, 1, -1, 20, 1},
        '{"-9223372036854775808", 10, 0, 0, 1, 64'h8000_0000_0000_0000, 20, 1},
        '{"-18446744073709551615", 10, 0, 0, 0, 0, 0, 0},
        '{"zz", 36, 0, 0, 1, 1295, 2, 1},
        '{"ZZ", 63, 0, 0, 1, 2240, 2, 1},
        '{"0101", 1, 0, 0, 1, 0, 1, 1},
        '{"abc", 10, 0, 0, 1, 0, 0, 0},
        '{"42", 10, 0, 1, 1, 42, 2, 1},
        '{"", 10, 0, 1, 1, 0, 0, 0},
        '{"-", 10, 0, 0, 1, 0, 0, 0},
        '{"+-5", 10, 0, 0, 1, 0, 0, 0},
        '{"7", 8, 0, 0, 1, 7, 1, 1},
        '{"  99", 16, 1, 0, 1, 99, 4, 1},
        '{"12a9", 11, 0, 0, 0, 0, 0, 0},
        '{"0x1g2", 0, 0, 0, 0, 0, 0, 0},
        '{"\377-5", 10, 0, 0, 1, 0, 0, 0},
        '{"9\177", 10, 0, 0, 1, 9, 1, 1}
    };

    // Parse state mirrored from the block.
    s2i_pkg::phase_t             ph      = s2i_pkg::PH_WS;
    logic                        neg     = 1'b0;
    logic [s2i_pkg::RADIX_W-1:0] rdx     = s2i_pkg::RADIX_DEC;
    logic [63:0]                 acc     = '0;
    logic [s2i_pkg::POS_W-1:0]   pos     = '0;
    logic [s2i_pkg::POS_W-1:0]   stop_at = '0;
    logic                        seen    = 1'b0;

    s2i_pkg::rsp_t parsed_q [$];
    pin_t          known_q  [$];
    int            fails      = 0;
    int            cycles     = 0;
    int            sent_items = 0;
    int            send_idle  = 24;
    int            rcv_idle   = 80;

    function automatic int digit_of(input logic [7:0] c);
        if (c >= s2i_pkg::CH_0 && c <= s2i_pkg::CH_9)
        begin
            return int'(c - s2i_pkg::CH_0);
        end
        if (c >= s2i_pkg::CH_LA && c <= s2i_pkg::CH_LZ)
        begin
            return int'(c - s2i_pkg::CH_LA) + 10;
        end
        if (c >= s2i_pkg::CH_UA && c <= s2i_pkg::CH_UZ)
        begin
            return int'(c - s2i_pkg::CH_UA) + 10;
        end
        return -1;
    endfunction

    function automatic bit blank(input logic [7:0] c);
        return c == s2i_pkg::CH_SPACE || c == s2i_pkg::CH_TAB || c == s2i_pkg::CH_LF ||
               c == s2i_pkg::CH_CR || c == s2i_pkg::CH_VT || c == s2i_pkg::CH_FF;
    endfunction

    function automatic void clear_parse();
        ph      = s2i_pkg::PH_WS;
        neg     = 1'b0;
        rdx     = s2i_pkg::RADIX_DEC;
        acc     = '0;
        pos     = '0;
        stop_at = '0;
        seen    = 1'b0;
    endfunction

    function automatic logic [s2i_pkg::POS_W-1:0] next_stop();
        return (pos >= s2i_pkg::MAX_LEN) ? s2i_pkg::POS_W'(s2i_pkg::MAX_LEN) : pos + 1'b1;
    endfunction

    function automatic void take_digit(input logic [7:0] c);
        int d;
        d = digit_of(c);
        if (d >= 0 && d < int'(rdx))
        begin
            acc     = acc * 64'(rdx) + 64'(d);
            seen    = 1'b1;
            stop_at = next_stop();
        end
        else
        begin
            ph = s2i_pkg::PH_DONE;
        end
    endfunction

    function automatic void take_start(input logic [7:0] c);
        if ((rdx == s2i_pkg::RADIX_AUTO || rdx == s2i_pkg::RADIX_HEX) && c == s2i_pkg::CH_0)
        begin
            acc     = '0;
            seen    = 1'b1;
            stop_at = next_stop();
            ph      = s2i_pkg::PH_ZERO;
        end
        else
        begin
            if (rdx == s2i_pkg::RADIX_AUTO)
            begin
                rdx = s2i_pkg::RADIX_DEC;
            end
            ph = s2i_pkg::PH_DIGITS;
            take_digit(c);
        end
    endfunction

    function automatic void parse_char(input s2i_pkg::req_t r, output bit done,
                                       output s2i_pkg::rsp_t res);
        int d;
        if (r.is_first)
        begin
            clear_parse();
            rdx = r.base_in;
        end
        case (ph)
            s2i_pkg::PH_WS:
            begin
                if (r.char_code == s2i_pkg::CH_MINUS)
                begin
                    neg = 1'b1;
                    ph  = s2i_pkg::PH_START;
                end
                else if (r.char_code == s2i_pkg::CH_PLUS)
                begin
                    ph = s2i_pkg::PH_START;
                end
                else if (!blank(r.char_code))
                begin
                    take_start(r.char_code);
                end
            end
            s2i_pkg::PH_START:
            begin
                take_start(r.char_code);
            end
            s2i_pkg::PH_ZERO:
            begin
                if (r.char_code == s2i_pkg::CH_LX || r.char_code == s2i_pkg::CH_UX)
                begin
                    ph = s2i_pkg::PH_XSEEN;
                end
                else
                begin
                    if (rdx == s2i_pkg::RADIX_AUTO)
                    begin
                        rdx = s2i_pkg::RADIX_OCT;
                    end
                    ph = s2i_pkg::PH_DIGITS;
                    take_digit(r.char_code);
                end
            end
            s2i_pkg::PH_XSEEN:
            begin
                // prefix counts only when a hex digit follows it
                d = digit_of(r.char_code);
                if (d >= 0 && d < 16)
                begin
                    rdx     = s2i_pkg::RADIX_HEX;
                    acc     = 64'(d);
                    stop_at = next_stop();
                    ph      = s2i_pkg::PH_DIGITS;
                end
                else
                begin
                    ph = s2i_pkg::PH_DONE;
                end
            end
            s2i_pkg::PH_DIGITS:
            begin
                take_digit(r.char_code);
            end
            default:
            begin
            end
        endcase
        if (pos < s2i_pkg::MAX_LEN)
        begin
            pos = pos + 1'b1;
        end
        done = r.is_last;
        res  = '0;
        if (done)
        begin
            res.value      = neg ? -acc : acc;
            res.end_offset = seen ? stop_at : '0;
            res.any_digits = seen;
            clear_parse();
        end
    endfunction

    // Predict on every accepted request, check every accepted result.
    always @(posedge clk)
    begin
        s2i_pkg::rsp_t got;
        s2i_pkg::rsp_t want;
        bit            done;
        pin_t          p;
        if (rst_n && req_valid && !req_stall)
        begin
            parse_char(req, done, got);
            if (done)
            begin
                p.pinned = 1'b0;
                p.want   = got;
                if (known_q.size() != 0)
                begin
                    p = known_q.pop_front();
                end
                parsed_q.push_back(p.pinned ? p.want : got);
            end
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (parsed_q.size() == 0)
            begin
                $display("%0t unexpected result: value %0d offset %0d digits %0b",
                         $time, rsp.value, rsp.end_offset, rsp.any_digits);
                fails++;
            end
            else
            begin
                want = parsed_q.pop_front();
                if (rsp.value !== want.value)
                begin
                    $display("%0t value: expected %0d, got %0d", $time, want.value, rsp.value);
                    fails++;
                end
                if (rsp.end_offset !== want.end_offset)
                begin
                    $display("%0t end_offset: expected %0d, got %0d",
                             $time, want.end_offset, rsp.end_offset);
                    fails++;
                end
                if (rsp.any_digits !== want.any_digits)
                begin
                    $display("%0t any_digits: expected %0b, got %0b",
                             $time, want.any_digits, rsp.any_digits);
                    fails++;
                end
            end
        end
        rsp_stall <= ($urandom_range(99) < rcv_idle);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic byte digit_char(input int d);
        if (d < 10)
        begin
            return byte'(s2i_pkg::CH_0 + d);
        end
        return byte'(($urandom_range(1) ? s2i_pkg::CH_LA : s2i_pkg::CH_UA) + d - 10);
    endfunction

    task automatic send_char(input s2i_pkg::req_t r, input pin_t p);
        if (r.is_last)
        begin
            known_q.push_back(p);
        end
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        sent_items++;
    endtask

    task automatic send_text(input byte txt [$], input logic [s2i_pkg::RADIX_W-1:0] base,
                             input bit with_first, input pin_t p);
        s2i_pkg::req_t r;
        foreach (txt[i])
        begin
            r.char_code = txt[i];
            r.is_first  = with_first && (i == 0);
            // base_in only matters on the first character; randomize it elsewhere
            r.base_in   = (i == 0) ? base : s2i_pkg::RADIX_W'($urandom_range(63));
            r.is_last   = (i == txt.size() - 1);
            send_char(r, p);
        end
    endtask

    task automatic drain_all();
        req_valid <= 1'b0;
        @(posedge clk);
        while (parsed_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly well-formed numbers: blanks, sign, prefix, digits, then an optional trailer.
    function automatic void build_number(ref byte txt [$],
                                         output logic [s2i_pkg::RADIX_W-1:0] base);
        byte blanks [6] = '{s2i_pkg::CH_SPACE, s2i_pkg::CH_TAB, s2i_pkg::CH_LF,
                            s2i_pkg::CH_CR, s2i_pkg::CH_VT, s2i_pkg::CH_FF};
        int  eff;
        int  n;
        int  form;
        txt.delete();
        case ($urandom_range(9))
            0, 1, 2: base = s2i_pkg::RADIX_AUTO;
            3:       base = s2i_pkg::RADIX_OCT;
            4, 5:    base = s2i_pkg::RADIX_DEC;
            6, 7:    base = s2i_pkg::RADIX_HEX;
            8:       base = s2i_pkg::RADIX_W'($urandom_range(1, 36));
            default: base = s2i_pkg::RADIX_W'($urandom_range(0, 63));
        endcase
        repeat ($urandom_range(0, 3))
        begin
            txt.push_back(blanks[$urandom_range(5)]);
        end
        case ($urandom_range(2))
            1: txt.push_back(s2i_pkg::CH_PLUS);
            2: txt.push_back(s2i_pkg::CH_MINUS);
            default: ;
        endcase
        eff = int'(base);
        if (base == s2i_pkg::RADIX_AUTO)
        begin
            form = $urandom_range(2);
            eff  = 10;
            if (form != 0)
            begin
                txt.push_back(s2i_pkg::CH_0);
                eff = 8;
            end
            if (form == 2)
            begin
                txt.push_back($urandom_range(1) ? s2i_pkg::CH_LX : s2i_pkg::CH_UX);
                eff = 16;
            end
        end
        else if (base == s2i_pkg::RADIX_HEX && $urandom_range(1))
        begin
            txt.push_back(s2i_pkg::CH_0);
            txt.push_back($urandom_range(1) ? s2i_pkg::CH_LX : s2i_pkg::CH_UX);
        end
        if (eff > 36)
        begin
            eff = 36;
        end
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 24) : $urandom_range(0, 8);
        repeat (n)
        begin
            txt.push_back(digit_char($urandom_range(eff - 1)));
        end
        case ($urandom_range(3))
            1: txt.push_back(8'h00);
            2: txt.push_back(byte'($urandom_range(255)));
            3:
            begin
                repeat ($urandom_range(1, 4))
                begin
                    txt.push_back(byte'($urandom_range(255)));
                end
            end
            default: ;
        endcase
        if (txt.size() == 0)
        begin
            txt.push_back(8'h00);
        end
    endfunction

    initial
    begin
        byte                         txt [$];
        logic [s2i_pkg::RADIX_W-1:0] base;
        pin_t                        p;
        s2i_pkg::req_t               r;
        int                          nstr;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            txt.delete();
            for (int k = 0; k < dir_tab[i].text.len(); k++)
            begin
                txt.push_back(dir_tab[i].text[k]);
            end
            if (dir_tab[i].nul_end)
            begin
                txt.push_back(8'h00);
            end
            p.pinned          = dir_tab[i].pinned;
            p.want.value      = dir_tab[i].value;
            p.want.end_offset = s2i_pkg::POS_W'(dir_tab[i].offset);
            p.want.any_digits = dir_tab[i].any;
            send_text(txt, dir_tab[i].base, !dir_tab[i].no_first, p);
        end
        drain_all();

        p.pinned   = 1'b0;
        p.want     = '0;
        sent_items = 0;
        nstr       = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            // hold the sender until all results are back, then swap idle rates or set both to zero
            if (send_idle == 24 && sent_items >= RANDOM_ITEMS / 3)
            begin
                drain_all();
                send_idle = 80;
                rcv_idle  = 24;
            end
            else if (send_idle == 80 && sent_items >= 2 * RANDOM_ITEMS / 3)
            begin
                drain_all();
                send_idle = 0;
                rcv_idle  = 0;
            end
            nstr++;
            if (nstr == 30)
            begin
                // long string: saturate position and end offset
                txt.delete();
                repeat (120) txt.push_back(s2i_pkg::CH_SPACE);
                txt.push_back(s2i_pkg::CH_MINUS);
                repeat (140) txt.push_back(digit_char($urandom_range(9)));
                send_text(txt, s2i_pkg::RADIX_DEC, 1'b1, p);
            end
            else if ($urandom_range(99) < 8)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    r.char_code = 8'($urandom_range(255));
                    r.is_first  = 1'($urandom_range(1));
                    r.base_in   = s2i_pkg::RADIX_W'($urandom_range(63));
                    r.is_last   = 1'($urandom_range(1));
                    send_char(r, p);
                end
            end
            else
            begin
                build_number(txt, base);
                // now and then continue without is_first
                send_text(txt, base, $urandom_range(19) != 0, p);
            end
        end
        drain_all();
        repeat (10) @(posedge clk);

        if (fails == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
rtl/s2i_pkg.sv
rtl/s2i_step.sv
rtl/string_to_integer_parser_core.sv
tb/tb_string_to_integer_parser_core.sv
